### rtl/sha_pkg.sv
`timescale 1ns / 1ps
package sha_pkg;
    localparam int BlockBytes = 64;

    typedef logic [31:0] t_word;

    // one classified beat handed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_cmd;

    localparam t_word IvTab [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word KTab [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };

    localparam logic [7:0] PadMark = 8'h80;

    function automatic t_word rotr(t_word x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction
endpackage

### rtl/sha_if.sv
`timescale 1ns / 1ps
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
    modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
    modport sink (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

### rtl/sha_fifo.sv
`timescale 1ns / 1ps
module sha_fifo
    import sha_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);
    t_cmd       r_mem [4];
    logic [2:0] r_wp, r_rp;

    assign o_full  = (r_wp[1:0] == r_rp[1:0]) && (r_wp[2] != r_rp[2]);
    assign o_empty = (r_wp == r_rp);
    assign o_cmd   = r_mem[r_rp[1:0]];

    // store beat at write pointer
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp[1:0]] <= i_cmd;
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= r_wp + 3'd1;
            if (i_pop && !o_empty) r_rp <= r_rp + 3'd1;
        end
    end
endmodule

### rtl/sha_core.sv
`timescale 1ns / 1ps
module sha_core
    import sha_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_empty,
    input  t_cmd         i_cmd,
    output logic         o_pop,
    sha_out_if.source    o_out
);
    typedef enum logic [5:0] {
        S_TAKE = 6'b000001,
        S_PAD  = 6'b000010,
        S_LOAD = 6'b000100,
        S_RND  = 6'b001000,
        S_ADD  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state      r_state;
    logic [5:0]  r_cnt;
    logic [63:0] r_len;
    t_word       r_h [8];
    t_word       r_v [8];
    t_word       r_w [16];
    logic [5:0]  r_rnd;
    logic        r_fin;   // closing block pending after this compression
    logic        r_two;   // padding needs a second block
    logic        r_last;  // current compression is the final one
    logic [2:0]  r_oidx;
    logic [5:0]  r_pp;

    t_word s0, s1, wn, big0, big1, ch, maj, t1, t2, wcur;
    logic [7:0] pad_byte;

    assign o_pop = (r_state == S_TAKE) && !r_fin && !i_empty;
    assign wcur  = r_w[0];

    // message schedule and round function
    always_comb begin
        s0   = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1   = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        wn   = s1 + r_w[9] + s0 + r_w[0];
        big1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1   = r_v[7] + big1 + ch + KTab[r_rnd] + wcur;
        big0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        maj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2   = big0 + maj;
    end

    // padding byte for position r_pp of a closing block
    always_comb begin
        if (r_pp >= 6'd56 && !r_two)
            pad_byte = r_len[8'd63 - {2'b00, r_pp[2:0], 3'b000} -: 8];
        else
            pad_byte = 8'h00;
    end

    assign o_out.valid       = (r_state == S_OUT);
    assign o_out.digest_word = r_h[r_oidx];
    assign o_out.word_index  = r_oidx;
    assign o_out.last_word   = (r_oidx == 3'd7);

    // gather bytes straight into the schedule words, shift them during rounds
    always_ff @(posedge i_clk) begin
        if (r_state == S_TAKE && !r_fin && !i_empty && i_cmd.byte_valid)
            r_w[r_cnt[5:2]][{~r_cnt[1:0], 3'b000} +: 8] <= i_cmd.data_byte;
        else if (r_state == S_TAKE && r_fin)
            r_w[r_cnt[5:2]][{~r_cnt[1:0], 3'b000} +: 8] <= PadMark;
        else if (r_state == S_PAD)
            r_w[r_pp[5:2]][{~r_pp[1:0], 3'b000} +: 8] <= pad_byte;
        else if (r_state == S_RND) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= wn;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_TAKE;
            r_cnt   <= '0;
            r_len   <= '0;
            r_fin   <= 1'b0;
            r_two   <= 1'b0;
            r_last  <= 1'b0;
            r_oidx  <= '0;
            r_pp    <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= IvTab[i];
        end else begin
            case (r_state)
                S_TAKE: begin
                    if (r_fin) begin
                        // place the mark, then fill the rest
                        r_fin <= 1'b0;
                        r_two <= (r_cnt >= 6'd56);
                        r_pp  <= r_cnt + 6'd1;
                        if (r_cnt == 6'd63) begin
                            r_last  <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_state <= S_PAD;
                        end
                    end else if (!i_empty) begin
                        if (i_cmd.byte_valid) begin
                            r_cnt <= r_cnt + 6'd1;
                            r_len <= r_len + 64'd8;
                        end
                        r_fin <= i_cmd.end_of_message;
                        if (i_cmd.byte_valid && r_cnt == 6'd63) begin
                            r_last  <= 1'b0;
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_PAD: begin
                    r_pp <= r_pp + 6'd1;
                    if (r_pp == 6'd63) begin
                        r_last  <= !r_two;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    r_rnd   <= '0;
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_rnd  <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= S_ADD;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    if (r_last) begin
                        r_oidx  <= '0;
                        r_state <= S_OUT;
                    end else if (r_two) begin
                        // second closing block: zeros and length
                        r_two   <= 1'b0;
                        r_pp    <= '0;
                        r_state <= S_PAD;
                    end else begin
                        r_state <= S_TAKE;
                    end
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            for (int i = 0; i < 8; i++) r_h[i] <= IvTab[i];
                            r_cnt   <= '0;
                            r_len   <= '0;
                            r_state <= S_TAKE;
                        end
                    end
                end
                default: r_state <= S_TAKE;
            endcase
        end
    end

    a_pop_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == S_TAKE && !r_fin) else $error("pop outside take");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(r_oidx))
        else $error("digest word dropped");
    a_rnd_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RND && r_rnd == 6'd63 |=> r_state == S_ADD)
        else $error("round count slip");
endmodule

### rtl/sha256_stream_hasher.sv
`timescale 1ns / 1ps
// After its last byte a full block is compressed (load, 64 rounds, add);
// closing places the mark, pads each closing block and runs one or two
// compressions, then gives one digest word per cycle while the sink is ready.
// Throughput: bytes are taken one per cycle while the queue holds beats,
// paused during compression on the single round unit. Reset: synchronous, active
// low; restores the initial hash values and clears counters and the queue.
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    sha_in_if.sink   i_in,
    sha_out_if.source o_out
);
    t_cmd f_cmd, q_cmd;
    logic q_full, q_empty, q_pop;

    // classify the beat: drop beats that carry nothing
    assign f_cmd.data_byte      = i_in.data_byte;
    assign f_cmd.byte_valid     = i_in.byte_valid;
    assign f_cmd.end_of_message = i_in.end_of_message;
    assign i_in.ready           = !q_full;

    sha_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in.valid && (i_in.byte_valid || i_in.end_of_message)),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty)
    );

    sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_cmd   (q_cmd),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );
endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import sha_pkg::*;

    typedef struct {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_beat;

    typedef struct {
        t_word      digest_word;
        logic [2:0] word_index;
        logic       last_word;
    } t_digest_beat;

    // Directed row: the beat, and an optional typed-in digest word 0
    typedef struct {
        t_beat beat;
        logic  has_known;
        t_word known_word0;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sha_in_if  in_ch ();
    sha_out_if out_ch ();

    sha256_stream_hasher dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state
    t_word      hash_state [8];
    logic [7:0] msg_block [64];
    logic [5:0] block_fill;
    logic [63:0] bit_count;

    t_digest_beat digest_queue [$];
    int  mismatch_count = 0;
    int  idle_cycles = 0;
    int  stall_left = 0;
    bit  stress_done = 1'b0;
    bit  quiet_tail = 1'b0;
    bit  sink_on = 1'b0;

    localparam t_word EmptyDigest0 = 32'he3b0c442;
    localparam t_word AbcDigest0   = 32'hba7816bf;
    localparam int    WatchLimit   = 4000;

    function automatic t_word ror32(t_word x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_msg_block();
        t_word w [64];
        t_word v [8];
        t_word t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTab[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endtask

    task automatic clear_hash_state();
        for (int i = 0; i < 8; i++) hash_state[i] = IvTab[i];
        block_fill = '0;
        bit_count = '0;
    endtask

    // Absorb one beat; queue the digest when the message closes
    task automatic absorb_beat(t_beat b);
        int pos;
        t_digest_beat d;
        if (b.byte_valid) begin
            msg_block[block_fill] = b.data_byte;
            block_fill = block_fill + 6'd1;
            bit_count = bit_count + 64'd8;
            if (block_fill == 6'd0) compress_msg_block();
        end
        if (b.end_of_message) begin
            pos = block_fill;
            msg_block[pos] = PadMark;
            pos++;
            if (pos > 56) begin
                while (pos < 64) begin msg_block[pos] = 8'h00; pos++; end
                compress_msg_block();
                pos = 0;
            end
            while (pos < 56) begin msg_block[pos] = 8'h00; pos++; end
            for (int i = 0; i < 8; i++) msg_block[56+i] = bit_count[63-8*i -: 8];
            compress_msg_block();
            for (int i = 0; i < 8; i++) begin
                d.digest_word = hash_state[i];
                d.word_index = 3'(i);
                d.last_word = (i == 7);
                digest_queue.push_back(d);
            end
            clear_hash_state();
        end
    endtask

    task automatic report_mismatch(string what, t_word exp_v, t_word act_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %s: expected %h actual %h", what, exp_v, act_v);
    endtask

    // Present one beat, sometimes after a random idle burst; hold valid between beats
    task automatic send_beat(t_beat b);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            in_ch.data_byte <= 8'($urandom);
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b.data_byte;
        in_ch.byte_valid <= b.byte_valid;
        in_ch.end_of_message <= b.end_of_message;
        do @(posedge i_clk); while (!in_ch.ready);
        absorb_beat(b);
        @(negedge i_clk);
    endtask

    task automatic send_message(int len, bit noisy);
        t_beat b;
        for (int i = 0; i < len; i++) begin
            if (noisy && $urandom_range(0, 9) == 0) begin
                b.data_byte = 8'($urandom); b.byte_valid = 1'b0; b.end_of_message = 1'b0;
                send_beat(b);
            end
            b.data_byte = 8'($urandom);
            b.byte_valid = 1'b1;
            b.end_of_message = (i == len - 1);
            send_beat(b);
        end
        if (len == 0) begin
            b.data_byte = 8'($urandom); b.byte_valid = 1'b0; b.end_of_message = 1'b1;
            send_beat(b);
        end
    endtask

    // Digest sink: stall in random bursts, always ready in the quiet tail
    always @(negedge i_clk) begin
        if (quiet_tail) begin
            sink_on <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            sink_on <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            sink_on <= 1'b0;
            stall_left <= $urandom_range(0, 16);
        end else begin
            sink_on <= 1'b1;
        end
    end
    assign out_ch.ready = sink_on;

    initial in_ch.valid = 1'b0;

    always @(posedge i_clk) begin
        t_digest_beat e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (digest_queue.size() == 0) begin
                report_mismatch("unexpected beat", 32'h0, out_ch.digest_word);
            end else begin
                e = digest_queue.pop_front();
                if (out_ch.digest_word !== e.digest_word)
                    report_mismatch("digest_word", e.digest_word, out_ch.digest_word);
                if (out_ch.word_index !== e.word_index)
                    report_mismatch("word_index", 32'(e.word_index), 32'(out_ch.word_index));
                if (out_ch.last_word !== e.last_word)
                    report_mismatch("last_word", 32'(e.last_word), 32'(out_ch.last_word));
            end
        end
    end

    // Watchdog on cycles with no beat moved on either channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (i_rst_n && idle_cycles >= WatchLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        t_row rows [$];
        t_row r;
        int msgs;
        in_ch.data_byte = 8'h00;
        in_ch.byte_valid = 1'b0;
        in_ch.end_of_message = 1'b0;
        clear_hash_state();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table: empty message, "abc", ignored beats, extreme bytes
        r.has_known = 1'b1; r.known_word0 = EmptyDigest0;
        r.beat = '{8'hff, 1'b0, 1'b1}; rows.push_back(r);
        r.has_known = 1'b0;
        r.beat = '{8'h61, 1'b1, 1'b0}; rows.push_back(r);
        r.beat = '{8'h55, 1'b0, 1'b0}; rows.push_back(r);
        r.beat = '{8'h62, 1'b1, 1'b0}; rows.push_back(r);
        r.has_known = 1'b1; r.known_word0 = AbcDigest0;
        r.beat = '{8'h63, 1'b1, 1'b1}; rows.push_back(r);
        r.has_known = 1'b0;
        r.beat = '{8'h00, 1'b1, 1'b0}; rows.push_back(r);
        r.beat = '{8'hff, 1'b1, 1'b0}; rows.push_back(r);
        r.beat = '{8'haa, 1'b0, 1'b1}; rows.push_back(r);
        r.beat = '{8'hff, 1'b1, 1'b1}; rows.push_back(r);
        r.beat = '{8'h00, 1'b1, 1'b1}; rows.push_back(r);
        foreach (rows[k]) begin
            send_beat(rows[k].beat);
            // the closing beat just queued its eight words at the tail
            if (rows[k].has_known &&
                digest_queue[digest_queue.size() - 8].digest_word !== rows[k].known_word0)
                report_mismatch("known digest", rows[k].known_word0,
                                digest_queue[digest_queue.size() - 8].digest_word);
        end

        // Padding edges: 55, 56, 63, 64 bytes
        send_message(55, 1'b0);
        send_message(56, 1'b0);
        send_message(63, 1'b0);
        send_message(64, 1'b1);

        // Random messages, mostly short; the last part runs without idling
        msgs = 0;
        while (msgs < 12) begin
            if (msgs >= 9) quiet_tail = 1'b1;
            case ($urandom_range(0, 5))
                0: send_message($urandom_range(0, 2), 1'b1);
                1: send_message($urandom_range(10, 20), 1'b1);
                default: send_message($urandom_range(1, 10), 1'b1);
            endcase
            msgs++;
        end
        in_ch.valid <= 1'b0;

        wait (digest_queue.size() == 0);
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0 && digest_queue.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

### sha256_stream_hasher.f
rtl/sha_pkg.sv
rtl/sha_if.sv
rtl/sha_fifo.sv
rtl/sha_core.sv
rtl/sha256_stream_hasher.sv
sim/tb_top.sv
